// ----- rtl/bd3_pkg.sv -----
// ----------------------------------------------------------------------------
// bd3_pkg
// Shared types, constants and helpers for the 3D box difference unit.
// ----------------------------------------------------------------------------
package bd3_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int NUM_AXES   = 3;
  localparam int NUM_PC     = 8;
  localparam int PC_BITS    = $clog2(NUM_PC);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  typedef logic [FIELD_BITS-1:0] field_t;
  // coordinates are kept as raw bits, compared through $signed
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0] len_t;

  // one bit per result kind; a word's mask lists the pieces still to emit
  typedef enum logic [PC_BITS-1:0] {
    PC_WHOLE = 3'd0,
    PC_XLO   = 3'd1,
    PC_XHI   = 3'd2,
    PC_YLO   = 3'd3,
    PC_YHI   = 3'd4,
    PC_ZLO   = 3'd5,
    PC_ZHI   = 3'd6,
    PC_NONE  = 3'd7
  } piece_e;

  typedef logic [NUM_PC-1:0] mask_t;

  // classified word handed from the front end to the back end
  typedef struct packed {
    coord_t [NUM_AXES-1:0] ao;
    len_t   [NUM_AXES-1:0] al;
    coord_t                xs;
    coord_t                ys;
    coord_t                xe;
    coord_t                ye;
    coord_t                ze;
    len_t   [NUM_AXES-1:0] lo_len;
    len_t   [NUM_AXES-1:0] hi_len;
    mask_t                 mask;
  } bd3_item_t;

  function automatic coord_t to_coord(field_t f);
    return coord_t'($signed(f));
  endfunction

  function automatic len_t to_len(field_t f);
    return len_t'(f);
  endfunction

  function automatic field_t coord_out(coord_t c);
    return field_t'($signed(c));
  endfunction

  function automatic field_t len_out(len_t l);
    return field_t'(l);
  endfunction

  function automatic logic slt(coord_t a, coord_t b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ----- rtl/box_difference_3d_unit.sv -----
// ----------------------------------------------------------------------------
// box_difference_3d_unit
// Splits box A minus box B into up to six disjoint boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive the A and B fields and raise
//   push; the word is taken on a clock edge with push high and full low.
//   Result side is a queue read port: while empty is low the oldest piece is
//   on the piece ports; it is taken on an edge with pop high.
//   Each input word gives one to six pieces, the final one with last_piece
//   set. A fully covered A gives one piece with empty_flag set, all zero.
// Flow: a taken word passes the second front stage and the queue write
//   before its first piece reaches the output register.
// Rate: the back end emits one piece per cycle while the output is empty
//   or pop is high, and holds a word until all its pieces are out. The front
//   end takes a word every cycle until its four-word queue and stages fill.
// Reset: asynchronous, active low; it empties both pipelines and the queue.
// Stall: with pop low the current piece holds; the queue and front stages
//   fill, then full rises.
// ----------------------------------------------------------------------------
module box_difference_3d_unit import bd3_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push,
  output logic   full,
  input  field_t a_off_x_i,
  input  field_t a_off_y_i,
  input  field_t a_off_z_i,
  input  field_t a_len_x_i,
  input  field_t a_len_y_i,
  input  field_t a_len_z_i,
  input  field_t b_off_x_i,
  input  field_t b_off_y_i,
  input  field_t b_off_z_i,
  input  field_t b_len_x_i,
  input  field_t b_len_y_i,
  input  field_t b_len_z_i,
  output logic   empty,
  input  logic   pop,
  output field_t piece_off_x_o,
  output field_t piece_off_y_o,
  output field_t piece_off_z_o,
  output field_t piece_len_x_o,
  output field_t piece_len_y_o,
  output field_t piece_len_z_o,
  output logic   empty_flag_o,
  output logic   last_piece_o
);

  logic      item_valid, q_full, q_empty, q_pop;
  bd3_item_t item_w, item_r;

  bd3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .a_off_i      ({a_off_z_i, a_off_y_i, a_off_x_i}),
    .a_len_i      ({a_len_z_i, a_len_y_i, a_len_x_i}),
    .b_off_i      ({b_off_z_i, b_off_y_i, b_off_x_i}),
    .b_len_i      ({b_len_z_i, b_len_y_i, b_len_x_i}),
    .item_valid_o (item_valid),
    .item_o       (item_w),
    .q_full_i     (q_full)
  );

  bd3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_valid),
    .wdata_i (item_w),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (item_r),
    .empty_o (q_empty)
  );

  bd3_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_r),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .piece_off_x_o (piece_off_x_o),
    .piece_off_y_o (piece_off_y_o),
    .piece_off_z_o (piece_off_z_o),
    .piece_len_x_o (piece_len_x_o),
    .piece_len_y_o (piece_len_y_o),
    .piece_len_z_o (piece_len_z_o),
    .empty_flag_o  (empty_flag_o),
    .last_piece_o  (last_piece_o)
  );

endmodule

// ----- rtl/bd3_front.sv -----
// ----------------------------------------------------------------------------
// bd3_front
// Two register stages: box ends, then per-axis compares. The last step
// clips piece lengths, builds the piece mask and writes the queue.
// ----------------------------------------------------------------------------
module bd3_front import bd3_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  field_t [NUM_AXES-1:0]  a_off_i,
  input  field_t [NUM_AXES-1:0]  a_len_i,
  input  field_t [NUM_AXES-1:0]  b_off_i,
  input  field_t [NUM_AXES-1:0]  b_len_i,
  output logic                   item_valid_o,
  output bd3_item_t              item_o,
  input  logic                   q_full_i
);

  // stage 1
  logic                   s1_valid_q;
  coord_t [NUM_AXES-1:0]  s1_ao_q, s1_bo_q, s1_amax_q, s1_bmax_q;
  len_t   [NUM_AXES-1:0]  s1_al_q;
  coord_t [NUM_AXES-1:0]  s1_ao_d, s1_bo_d, s1_amax_d, s1_bmax_d;
  len_t   [NUM_AXES-1:0]  s1_al_d;

  // stage 2
  logic                   s2_valid_q;
  coord_t [NUM_AXES-1:0]  s2_ao_q, s2_mn_q;
  len_t   [NUM_AXES-1:0]  s2_al_q, s2_dlo_q, s2_dhi_q;
  coord_t                 s2_xs_q, s2_ys_q;
  logic   [NUM_AXES-1:0]  s2_lt_lo_q, s2_gt_hi_q;
  logic                   s2_ov_q;
  coord_t [NUM_AXES-1:0]  s2_mn_d;
  len_t   [NUM_AXES-1:0]  s2_dlo_d, s2_dhi_d;
  coord_t                 s2_xs_d, s2_ys_d;
  logic   [NUM_AXES-1:0]  s2_lt_lo_d, s2_gt_hi_d, s2_ov_ax;

  // stage 3 (combinational into queue)
  coord_t [NUM_AXES-1:0]  ends;
  len_t   [NUM_AXES-1:0]  lo_len, hi_len;
  logic                   y_ok;
  mask_t                  mask;

  logic s1_ready, s2_ready, s1_take;

  assign s2_ready = !s2_valid_q || !q_full_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign full_o   = !s1_ready;
  assign s1_take  = push_i && s1_ready;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      s1_ao_d[i]   = to_coord(a_off_i[i]);
      s1_bo_d[i]   = to_coord(b_off_i[i]);
      s1_al_d[i]   = to_len(a_len_i[i]);
      s1_amax_d[i] = s1_ao_d[i] + coord_t'(s1_al_d[i]) - coord_t'(1);
      s1_bmax_d[i] = s1_bo_d[i] + coord_t'(to_len(b_len_i[i])) - coord_t'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      s2_lt_lo_d[i] = slt(s1_ao_q[i], s1_bo_q[i]);
      s2_gt_hi_d[i] = slt(s1_bmax_q[i], s1_amax_q[i]);
      s2_ov_ax[i]   = !(slt(s1_bmax_q[i], s1_ao_q[i]) || slt(s1_amax_q[i], s1_bo_q[i]));
      s2_mn_d[i]    = s2_gt_hi_d[i] ? s1_bmax_q[i] : s1_amax_q[i];
      s2_dlo_d[i]   = len_t'(s1_bo_q[i] - s1_ao_q[i]);
      s2_dhi_d[i]   = len_t'(s1_amax_q[i] - s1_bmax_q[i]);
    end
    s2_xs_d = s2_lt_lo_d[0] ? s1_bo_q[0] : s1_ao_q[0];
    s2_ys_d = s2_lt_lo_d[1] ? s1_bo_q[1] : s1_ao_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= push_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_ao_q   <= s1_ao_d;
      s1_bo_q   <= s1_bo_d;
      s1_al_q   <= s1_al_d;
      s1_amax_q <= s1_amax_d;
      s1_bmax_q <= s1_bmax_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_ao_q     <= s1_ao_q;
      s2_al_q     <= s1_al_q;
      s2_mn_q     <= s2_mn_d;
      s2_dlo_q    <= s2_dlo_d;
      s2_dhi_q    <= s2_dhi_d;
      s2_xs_q     <= s2_xs_d;
      s2_ys_q     <= s2_ys_d;
      s2_lt_lo_q  <= s2_lt_lo_d;
      s2_gt_hi_q  <= s2_gt_hi_d;
      s2_ov_q     <= &s2_ov_ax;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      ends[i]   = s2_mn_q[i] + coord_t'(1);
      lo_len[i] = (s2_dlo_q[i] < s2_al_q[i]) ? s2_dlo_q[i] : s2_al_q[i];
      hi_len[i] = (s2_dhi_q[i] < s2_al_q[i]) ? s2_dhi_q[i] : s2_al_q[i];
    end
    // y end can wrap past the top of the range, which kills the z pieces
    y_ok = !slt(ends[1], s2_ys_q);
    mask = '0;
    if (!s2_ov_q) begin
      mask[PC_WHOLE] = 1'b1;
    end else begin
      mask[PC_XLO] = s2_lt_lo_q[0];
      mask[PC_XHI] = s2_gt_hi_q[0];
      mask[PC_YLO] = s2_lt_lo_q[1];
      mask[PC_YHI] = s2_gt_hi_q[1];
      mask[PC_ZLO] = s2_lt_lo_q[2] && y_ok;
      mask[PC_ZHI] = s2_gt_hi_q[2] && y_ok;
      if (mask == '0) mask[PC_NONE] = 1'b1;
    end
  end

  assign item_valid_o  = s2_valid_q && !q_full_i;
  assign item_o.ao     = s2_ao_q;
  assign item_o.al     = s2_al_q;
  assign item_o.xs     = s2_xs_q;
  assign item_o.ys     = s2_ys_q;
  assign item_o.xe     = ends[0];
  assign item_o.ye     = ends[1];
  assign item_o.ze     = ends[2];
  assign item_o.lo_len = lo_len;
  assign item_o.hi_len = hi_len;
  assign item_o.mask   = mask;

  a_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_o |-> item_o.mask != '0)
    else $error("front: empty piece mask pushed");

  a_whole_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_o && (item_o.mask[PC_WHOLE] || item_o.mask[PC_NONE])
      |-> $onehot(item_o.mask))
    else $error("front: whole/none piece mixed with others");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> s1_valid_q && s2_valid_q)
    else $error("front: full without both stages occupied");

endmodule

// ----- rtl/bd3_fifo.sv -----
// ----------------------------------------------------------------------------
// bd3_fifo
// Short queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module bd3_fifo import bd3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bd3_item_t wdata_i,
  output logic      full_o,
  input  logic      pop_i,
  output bd3_item_t rdata_o,
  output logic      empty_o
);

  bd3_item_t mem_q [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_BITS:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == (Q_PTR_BITS+1)'(Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + Q_PTR_BITS'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + Q_PTR_BITS'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + (Q_PTR_BITS+1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (Q_PTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Q_PTR_BITS+1)'(Q_DEPTH))
    else $error("fifo: count past depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (empty_o || full_o))
    else $error("fifo: pointers equal with partial fill");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + (Q_PTR_BITS+1)'(1))
    else $error("fifo: count missed a push");

endmodule

// ----- rtl/bd3_back.sv -----
// ----------------------------------------------------------------------------
// bd3_back
// Walks the head word's piece mask into the output register, one piece per
// cycle while it is empty or popped; pops the queue with a word's last piece.
// ----------------------------------------------------------------------------
module bd3_back import bd3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bd3_item_t item_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output field_t    piece_off_x_o,
  output field_t    piece_off_y_o,
  output field_t    piece_off_z_o,
  output field_t    piece_len_x_o,
  output field_t    piece_len_y_o,
  output field_t    piece_len_z_o,
  output logic      empty_flag_o,
  output logic      last_piece_o
);

  logic   busy_q, busy_d;
  mask_t  rem_q, rem_d;
  logic   out_valid_q;
  coord_t off_x_q, off_y_q, off_z_q;
  len_t   len_x_q, len_y_q, len_z_q;
  logic   empty_flag_q, last_q;

  mask_t  cur_mask, rest;
  piece_e sel;
  logic   emit, done;
  len_t   xw, yw;
  coord_t xhi_off;
  coord_t off_x_d, off_y_d, off_z_d;
  len_t   len_x_d, len_y_d, len_z_d;
  logic   empty_flag_d;

  assign cur_mask = busy_q ? rem_q : item_i.mask;

  always_comb begin
    sel = PC_NONE;
    for (int i = NUM_PC - 1; i >= 0; i--) begin
      if (cur_mask[i]) sel = piece_e'(PC_BITS'(i));
    end
  end

  assign rest    = cur_mask & ~(mask_t'(1) << sel);
  assign done    = rest == '0;
  assign emit    = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = emit && done;

  assign xw      = len_t'(item_i.xe - item_i.xs);
  assign yw      = len_t'(item_i.ye - item_i.ys);
  assign xhi_off = slt(item_i.xe, item_i.ao[0]) ? item_i.ao[0] : item_i.xe;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    if (emit) begin
      busy_d = !done;
      rem_d  = rest;
    end
  end

  always_comb begin
    off_x_d      = item_i.ao[0];
    off_y_d      = item_i.ao[1];
    off_z_d      = item_i.ao[2];
    len_x_d      = item_i.al[0];
    len_y_d      = item_i.al[1];
    len_z_d      = item_i.al[2];
    empty_flag_d = 1'b0;
    unique case (sel)
      PC_WHOLE: ;
      PC_XLO: len_x_d = item_i.lo_len[0];
      PC_XHI: begin
        off_x_d = xhi_off;
        len_x_d = item_i.hi_len[0];
      end
      PC_YLO: begin
        off_x_d = item_i.xs;
        len_x_d = xw;
        len_y_d = item_i.lo_len[1];
      end
      PC_YHI: begin
        off_x_d = item_i.xs;
        off_y_d = item_i.ye;
        len_x_d = xw;
        len_y_d = item_i.hi_len[1];
      end
      PC_ZLO: begin
        off_x_d = item_i.xs;
        off_y_d = item_i.ys;
        len_x_d = xw;
        len_y_d = yw;
        len_z_d = item_i.lo_len[2];
      end
      PC_ZHI: begin
        off_x_d = item_i.xs;
        off_y_d = item_i.ys;
        off_z_d = item_i.ze;
        len_x_d = xw;
        len_y_d = yw;
        len_z_d = item_i.hi_len[2];
      end
      PC_NONE: begin
        off_x_d      = '0;
        off_y_d      = '0;
        off_z_d      = '0;
        len_x_d      = '0;
        len_y_d      = '0;
        len_z_d      = '0;
        empty_flag_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      if (emit)       out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      off_x_q      <= off_x_d;
      off_y_q      <= off_y_d;
      off_z_q      <= off_z_d;
      len_x_q      <= len_x_d;
      len_y_q      <= len_y_d;
      len_z_q      <= len_z_d;
      empty_flag_q <= empty_flag_d;
      last_q       <= done;
    end
  end

  assign empty_o       = !out_valid_q;
  assign piece_off_x_o = coord_out(off_x_q);
  assign piece_off_y_o = coord_out(off_y_q);
  assign piece_off_z_o = coord_out(off_z_q);
  assign piece_len_x_o = len_out(len_x_q);
  assign piece_len_y_o = len_out(len_y_q);
  assign piece_len_z_o = len_out(len_z_q);
  assign empty_flag_o  = empty_flag_q;
  assign last_piece_o  = last_q;

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && empty_flag_q |-> last_q)
    else $error("back: empty result not marked last");

  a_busy_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !q_empty_i && rem_q != '0)
    else $error("back: mid-word with nothing left");

  a_busy_no_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !rem_q[PC_WHOLE] && !rem_q[PC_NONE])
    else $error("back: single-result kind left over");

endmodule
